[rtl/lee_pkg.sv]
// Shared types and constants for the line editor with erase and kill.
package lee_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned LINE_DEPTH  = 64;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [CHAR_W-1:0] RESET_ERASE = 8'd35;  // '#'
    localparam logic [CHAR_W-1:0] RESET_KILL  = 8'd64;  // '@'
    localparam logic [CHAR_W-1:0] RESET_EOL   = 8'd10;  // newline

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ERASE = 2'd0,
        CFG_KILL  = 2'd1,
        CFG_EOL   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_ERASE = 2'd1,
        OP_KILL  = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE = 2'd0,
        BS_READ = 2'd1,
        BS_LOAD = 2'd2
    } t_bstate;

endpackage

[rtl/line_editor_erase_kill.sv]
// Top level of the line editor with erase and kill characters.
//
// Usage: characters enter on the s_axis channel, one item per character;
// s_axis_tuser set marks end of text (the character is then ignored).
// The erase character drops the last stored character, the kill character
// clears the line, anything else is stored (up to LINE_DEPTH characters;
// overflow drops the character and sets a lost flag for that line).
// The end-of-line character or end of text flushes the line on m_axis,
// oldest first, tlast on the final character, tuser = characters lost.
// An empty line produces nothing.
// Flow: an item enters a 4-entry command queue and is applied from its
// head while the back end is idle; plain characters sustain one per cycle
// outside a flush. A flush walks the line through a read state and a load
// state for each character, oldest first; the load waits for a free output
// register. The queue keeps taking items during a flush and holds off
// input (tready low) once full.
// Control characters are written on the i_cfg_* port while idle.
// Reset (synchronous, active low) empties the line, clears the lost flag
// and restores '#', '@' and newline as erase, kill and end of line.
// A stalled receiver holds the output register and pauses the flush.
module line_editor_erase_kill import lee_pkg::*; #(
    parameter int unsigned LINE_DEPTH_P = LINE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHAR_W-1:0]    i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] ch
    input  logic                 s_axis_tuser,   // [0] end_of_text
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [CHAR_W-1:0]    m_axis_tdata,   // [7:0] out_char
    output logic                 m_axis_tlast,   // last_of_line
    output logic                 m_axis_tuser    // [0] chars_lost
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_valid;
    logic back_ready;

    lee_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_ch       (s_axis_tdata),
        .i_eot      (s_axis_tuser),
        .o_cmd      (front_cmd)
    );

    lee_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_axis_tvalid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (s_axis_tready),
        .o_pop_valid  (queue_valid),
        .o_pop_cmd    (queue_cmd),
        .i_pop_ready  (back_ready)
    );

    lee_back #(
        .DEPTH (LINE_DEPTH_P)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_ready (back_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_lost      (m_axis_tuser)
    );

endmodule

[rtl/lee_front.sv]
// Front end: holds the control characters and classifies each input item.
module lee_front import lee_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHAR_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    input  logic [CHAR_W-1:0]    i_ch,
    input  logic                 i_eot,
    output t_cmd                 o_cmd
);

    logic [CHAR_W-1:0] r_erase;
    logic [CHAR_W-1:0] r_kill;
    logic [CHAR_W-1:0] r_eol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase <= RESET_ERASE;
            r_kill  <= RESET_KILL;
            r_eol   <= RESET_EOL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ERASE: r_erase <= i_cfg_data;
                CFG_KILL:  r_kill  <= i_cfg_data;
                CFG_EOL:   r_eol   <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // priority: end of line, then erase, then kill
    always_comb begin
        o_cmd.ch = i_ch;
        if (i_eot || i_ch == r_eol) begin
            o_cmd.op = OP_FLUSH;
        end else if (i_ch == r_erase) begin
            o_cmd.op = OP_ERASE;
        end else if (i_ch == r_kill) begin
            o_cmd.op = OP_KILL;
        end else begin
            o_cmd.op = OP_PUSH;
        end
        if (!i_valid) begin
            o_cmd.op = OP_PUSH;
        end
    end

endmodule

[rtl/lee_queue.sv]
// Small command queue between the front end and the line store engine.
module lee_queue import lee_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop_ready
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

[rtl/lee_back.sv]
// Back end: line store, fill count, lost flag and the flush walker.
module lee_back import lee_pkg::*; #(
    parameter int unsigned DEPTH = LINE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last,
    output logic              o_lost
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;
    t_bstate           r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_lost, n_lost;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_out_lost;
    logic              wr_en;
    logic              rd_en;
    logic              out_load;
    logic              out_free;
    logic              is_last;

    assign o_cmd_ready = (r_state == BS_IDLE);
    assign out_free    = !r_out_valid || i_ready;
    assign is_last     = (CW'(r_idx) + CW'(1)) == r_count;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lost   = r_lost;
        n_idx    = r_idx;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_PUSH: begin
                            if (r_count < CW'(DEPTH)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_lost = 1'b1;
                            end
                        end
                        OP_ERASE: begin
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_KILL: n_count = '0;
                        OP_FLUSH: begin
                            if (r_count == '0) begin
                                n_lost = 1'b0;
                            end else begin
                                n_idx   = '0;
                                n_state = BS_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_READ: begin
                rd_en   = 1'b1;
                n_state = BS_LOAD;
            end
            BS_LOAD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (is_last) begin
                        n_count = '0;
                        n_lost  = 1'b0;
                        n_state = BS_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = BS_READ;
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
        n_out_valid = out_load ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_count     <= '0;
            r_lost      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_lost      <= n_lost;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_cmd.ch;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_char <= r_rd_data;
            r_out_last <= is_last;
            r_out_lost <= r_lost;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;
    assign o_lost  = r_out_lost;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above line depth");

    a_walk_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BS_IDLE) |-> (CW'(r_idx) < r_count))
        else $error("flush index past stored line");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && is_last) |=> (r_count == '0 && !r_lost && r_state == BS_IDLE))
        else $error("line not cleared after last character");

    a_no_cmd_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BS_IDLE) |=> $stable(r_count) || (r_count == '0))
        else $error("fill count changed during flush");

endmodule

[test/tb_line_editor_erase_kill.sv]
// Self-checking testbench for the line editor with erase and kill characters.
`timescale 1ns / 100ps

// Characters go in on s_axis and are scored against a line-store predictor
// kept here. Flushed lines come back on m_axis and are compared field by
// field in order. Both sides idle at random. One phase holds the output off
// for a long stretch so the block backs up.
module tb_line_editor_erase_kill;
    import lee_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;  // unmapped index, write ignored
    localparam int HOLD_CYCLES  = 400;   // long output hold-off
    localparam int TAIL_CYCLES  = 16;    // queue + apply latency, with margin
    localparam int QUIET_LIMIT  = 3000;  // cycles without any handshake or register write

    // one input item and one flushed character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eot;
    } t_key_item;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              lost;
    } t_line_char;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CHAR_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [CHAR_W-1:0]    s_axis_tdata = '0;   // [7:0] ch
    logic                 s_axis_tuser = 1'b0; // [0] end_of_text
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]    m_axis_tdata;        // [7:0] out_char
    logic                 m_axis_tlast;        // last_of_line
    logic                 m_axis_tuser;        // [0] chars_lost

    line_editor_erase_kill i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor: control codes, line store, fill and lost flag
    // ---------------------------------------------------------------
    logic [CHAR_W-1:0] code_erase = RESET_ERASE;
    logic [CHAR_W-1:0] code_kill  = RESET_KILL;
    logic [CHAR_W-1:0] code_eol   = RESET_EOL;
    logic [CHAR_W-1:0] line_mem [LINE_DEPTH];
    int                line_fill = 0;
    logic              line_lost = 1'b0;

    t_key_item  key_q[$];         // items waiting to be sent
    t_line_char flushed_q[$];     // characters the block still owes us

    // Apply one accepted item; a flush queues the whole line oldest first.
    // Priority on shared codes: end of line, then erase, then kill.
    function automatic void edit_line(t_key_item it);
        if (it.eot || it.ch == code_eol) begin
            for (int k = 0; k < line_fill; k++)
                flushed_q.push_back('{line_mem[k], k == line_fill - 1, line_lost});
            line_fill = 0;
            line_lost = 1'b0;   // cleared even when the line was empty
        end else if (it.ch == code_erase) begin
            if (line_fill > 0)
                line_fill--;
        end else if (it.ch == code_kill) begin
            line_fill = 0;      // lost flag survives a kill
        end else if (line_fill < LINE_DEPTH) begin
            line_mem[line_fill] = it.ch;
            line_fill++;
        end else begin
            line_lost = 1'b1;   // store full, character dropped
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued items, random gaps between them
    // ---------------------------------------------------------------
    t_key_item tx_item;
    logic      tx_busy = 1'b0;
    int        tx_gap = 0;
    logic      calm = 1'b0;       // last part of the run: no idling at all
    int        items_in = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_busy = 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                edit_line(tx_item);
                items_in++;
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (key_q.size() > 0) begin
                    tx_item = key_q.pop_front();
                    tx_busy = 1'b1;
                    s_axis_tdata <= tx_item.ch;
                    s_axis_tuser <= tx_item.eot;
                    // gap follows this item once it is taken
                    if (!calm && $urandom_range(0, 5) == 0)
                        tx_gap = $urandom_range(1, 13);
                end
            end
            // valid stays high across back-to-back items: one assignment per edge
            s_axis_tvalid <= tx_busy;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random stalls, one long hold-off on request, checking
    // ---------------------------------------------------------------
    int hold_ask = 0;     // bumped by the stimulus to ask for a long hold-off
    int hold_seen = 0;
    int rx_hold = 0;
    int rx_stall = 0;
    int mismatches = 0;
    int chars_out = 0;
    int lines_out = 0;
    int lost_lines = 0;
    t_line_char got_char;
    t_line_char want_char;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
            rx_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_char = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
                chars_out++;
                if (got_char.last) begin
                    lines_out++;
                    if (got_char.lost)
                        lost_lines++;
                end
                if (flushed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected char %h last %b lost %b", $realtime,
                                 got_char.ch, got_char.last, got_char.lost);
                end else begin
                    want_char = flushed_q.pop_front();
                    if (got_char !== want_char) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: char exp %h got %h, last exp %b got %b,",
                                      " lost exp %b got %b"},
                                     $realtime, want_char.ch, got_char.ch, want_char.last,
                                     got_char.last, want_char.lost, got_char.lost);
                    end
                end
            end
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0)
                rx_hold--;
            else if (rx_stall > 0)
                rx_stall--;
            else if (!calm && $urandom_range(0, 7) == 0)
                rx_stall = $urandom_range(1, 13);
            m_axis_tready <= (rx_hold == 0 && rx_stall == 0);
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: any handshake or register write counts as progress
    // ---------------------------------------------------------------
    int quiet = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d chars still owed",
                     $realtime, QUIET_LIMIT, flushed_q.size());
            $display("tb_line_editor_erase_kill: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    int queued = 0;

    task automatic queue_item(logic [CHAR_W-1:0] c, logic e);
        key_q.push_back('{c, e});
        queued++;
    endtask

    // One well-formed line: content, optional edits, then end of line or
    // end of text. Overlong lines may get an erase or kill after overflow.
    task automatic queue_line(int len, bit edits);
        logic [CHAR_W-1:0] c;
        int                r;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (edits && r < 8) begin
                c = code_erase;
            end else if (edits && r < 10) begin
                c = code_kill;
            end else begin
                c = CHAR_W'($urandom_range(0, 255));
                if (c == code_eol)
                    c = c ^ 8'h80;
            end
            queue_item(c, 1'b0);
        end
        if (len > LINE_DEPTH && $urandom_range(0, 1) == 1)
            queue_item($urandom_range(0, 1) ? code_erase : code_kill, 1'b0);
        if ($urandom_range(0, 3) == 0)
            queue_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
        else
            queue_item(code_eol, 1'b0);
    endtask

    // Mostly short edited lines, a few long ones that may overflow, some stray items.
    task automatic random_lines(int budget);
        int stop_at;
        stop_at = queued + budget;
        while (queued < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                queue_item(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            else if ($urandom_range(0, 11) == 0)
                queue_line($urandom_range(60, 72), 1'b0);
            else
                queue_line($urandom_range(0, 12), 1'b1);
        end
    endtask

    // Wait until everything sent is taken and answered, then let the
    // block finish items that flush nothing.
    task automatic drain();
        do @(negedge i_clk);
        while (key_q.size() != 0 || tx_busy || flushed_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // Write enable is left high; the caller drops it.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CHAR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ERASE: code_erase = val;
            CFG_KILL:  code_kill  = val;
            CFG_EOL:   code_eol   = val;
            default: ;
        endcase
    endtask

    task automatic set_codes(logic [CHAR_W-1:0] er, logic [CHAR_W-1:0] kl,
                             logic [CHAR_W-1:0] el);
        cfg_write(CFG_ERASE, er);
        cfg_write(CFG_KILL, kl);
        cfg_write(CFG_EOL, el);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset codes: erase down past empty, byte extremes
        queue_item(8'h61, 1'b0);
        queue_item(RESET_ERASE, 1'b0);
        queue_item(RESET_ERASE, 1'b0);      // erase on an empty line
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(RESET_EOL, 1'b0);
        queue_item(RESET_EOL, 1'b0);        // empty line flushes nothing
        // kill, then end of text carrying the end-of-line code
        queue_item(8'h78, 1'b0);
        queue_item(8'h79, 1'b0);
        queue_item(RESET_KILL, 1'b0);
        queue_item(8'h7A, 1'b0);
        queue_item(RESET_EOL, 1'b1);
        queue_item(8'h55, 1'b1);            // end of text on an empty line
        // end of text overrides an erase code in ch
        queue_item(8'h71, 1'b0);
        queue_item(RESET_ERASE, 1'b1);
        queue_item(8'h7F, 1'b0);
        queue_item(8'h80, 1'b0);
        queue_item(8'hAA, 1'b1);
        drain();

        // low/high extremes for erase and kill
        set_codes(8'h00, 8'hFF, 8'h0D);
        random_lines(55);
        drain();

        // all three codes equal: end of line wins
        set_codes(8'h41, 8'h41, 8'h41);
        queue_item(8'h62, 1'b0);
        queue_item(8'h41, 1'b0);
        queue_item(8'h63, 1'b0);
        queue_item(8'h41, 1'b0);
        drain();

        // erase equals kill: erase wins; unmapped index must not stick
        cfg_write(CFG_NONE, 8'h64);
        set_codes(8'h42, 8'h42, 8'h00);
        queue_item(8'h64, 1'b0);
        queue_item(8'h65, 1'b0);
        queue_item(8'h42, 1'b0);
        queue_item(8'h64, 1'b0);            // still a plain character
        queue_item(8'h00, 1'b0);
        random_lines(45);
        drain();

        // Pressure: hold the output off while an overflowing line and
        // more traffic arrive, so the flush stalls and input backs up.
        set_codes(8'hFF, 8'h00, 8'hFF);
        hold_ask = hold_ask + 1;
        queue_line(66, 1'b0);
        random_lines(55);
        drain();

        // back to reset codes, no idling on either side
        set_codes(RESET_ERASE, RESET_KILL, RESET_EOL);
        calm = 1'b1;
        random_lines(40);
        drain();

        $display("%0d items sent, %0d chars back on %0d lines (%0d with lost chars)",
                 items_in, chars_out, lines_out, lost_lines);
        $display("five code settings incl. shared codes, extremes and a long output stall");
        if (mismatches == 0 && flushed_q.size() == 0) begin
            $display("tb_line_editor_erase_kill: done, clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_line_editor_erase_kill: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lee_pkg.sv
rtl/lee_front.sv
rtl/lee_queue.sv
rtl/lee_back.sv
rtl/line_editor_erase_kill.sv
test/tb_line_editor_erase_kill.sv
